// ===== rtl/csed_pkg.sv =====
`default_nettype none

package csed_pkg;

  localparam int OqDepth = 4;
  localparam int OqAw    = $clog2(OqDepth);
  localparam int OqCw    = $clog2(OqDepth + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_V      = 8'h76;

  localparam logic [7:0] BY_BEL = 8'h07;
  localparam logic [7:0] BY_BS  = 8'h08;
  localparam logic [7:0] BY_HT  = 8'h09;
  localparam logic [7:0] BY_LF  = 8'h0A;
  localparam logic [7:0] BY_VT  = 8'h0B;
  localparam logic [7:0] BY_FF  = 8'h0C;
  localparam logic [7:0] BY_CR  = 8'h0D;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_ESCAPE   = 3'd1,
    ST_LATE_QUOTE   = 3'd2,
    ST_MISSING_QUOTE = 3'd3,
    ST_UNTERMINATED = 3'd4
  } status_t;

  typedef struct packed {
    logic        in_escape;
    logic [1:0]  digit_count;
    logic [7:0]  digit_value;
    logic        inside_quotes;
    logic        past_first_char;
    logic [15:0] byte_count;
  } state_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        done_res;
    status_t     status;
    logic [7:0]  bad_char;
    logic [15:0] decoded_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    has;
    result_t res;
    state_t  st;
  } plain_out_t;

endpackage

`default_nettype wire

// ===== rtl/c_string_escape_decoder.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    char_in, end_of_text
// output    out_valid / out_ready  data_byte, byte_valid, done_res, status,
//                                  bad_char, decoded_length, last
// config    cfg_write_en           cfg_write_data (quote_required)
//
// An item is decoded in the cycle it is accepted; its zero, one or two results
// are written into a four-entry result queue whose head drives the output.
// One item per cycle is taken while the queue has room for two results; items
// with two results therefore limit throughput to the output rate (one per cycle at most).
// Synchronous reset clears the parser state, the queue and quote_required.
// Output stalls only back up the queue; in_ready depends on queue fill alone.
`default_nettype none

module c_string_escape_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_in,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data_byte,
  output logic        byte_valid,
  output logic        done_res,
  output logic [2:0]  status,
  output logic [7:0]  bad_char,
  output logic [15:0] decoded_length,
  output logic        last
);
  import csed_pkg::*;

  state_t     st;
  state_t     st_next;
  logic       quote_required;
  result_t    res0;
  result_t    res1;
  result_t    head;
  logic [1:0] res_count;
  logic       accept;

  assign accept = in_valid && in_ready;

  csed_step u_step (
    .st             (st),
    .quote_required (quote_required),
    .char_in        (char_in),
    .end_of_text    (end_of_text),
    .st_next        (st_next),
    .res0           (res0),
    .res1           (res1),
    .res_count      (res_count)
  );

  csed_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (accept ? res_count : 2'd0),
    .push0      (res0),
    .push1      (res1),
    .room       (in_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .head       (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= '0;
      quote_required <= 1'b0;
    end else begin
      if (accept) begin
        st <= st_next;
      end
      if (cfg_write_en) begin
        quote_required <= cfg_write_data;
      end
    end
  end

  assign data_byte      = head.data_byte;
  assign byte_valid     = head.byte_valid;
  assign done_res       = head.done_res;
  assign status         = head.status;
  assign bad_char       = head.bad_char;
  assign decoded_length = head.decoded_length;
  assign last           = head.last;

endmodule

`default_nettype wire

// ===== rtl/csed_step.sv =====
`default_nettype none

module csed_step (
  input  csed_pkg::state_t  st,
  input  logic              quote_required,
  input  logic [7:0]        char_in,
  input  logic              end_of_text,
  output csed_pkg::state_t  st_next,
  output csed_pkg::result_t res0,
  output csed_pkg::result_t res1,
  output logic [1:0]        res_count
);
  import csed_pkg::*;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == LEN_MAX) ? v : v + 16'd1;
  endfunction

  function automatic result_t byte_res(input logic [7:0] b, input logic [15:0] len);
    result_t r;
    r                = '0;
    r.data_byte      = b;
    r.byte_valid     = 1'b1;
    r.status         = ST_OK;
    r.decoded_length = len;
    byte_res         = r;
  endfunction

  function automatic result_t done_res_f(input status_t s, input logic [7:0] bad,
                                         input logic [15:0] len);
    result_t r;
    r                = '0;
    r.done_res       = 1'b1;
    r.status         = s;
    r.bad_char       = bad;
    r.decoded_length = len;
    done_res_f       = r;
  endfunction

  function automatic plain_out_t plain_char(input state_t s, input logic qr,
                                            input logic [7:0] c);
    plain_out_t p;
    p.has = 1'b0;
    p.res = '0;
    p.st  = s;
    if (c == CH_QUOTE) begin
      if (s.inside_quotes) begin
        p.has = 1'b1;
        p.res = done_res_f(ST_OK, 8'd0, s.byte_count);
        p.st  = '0;
      end else if (s.past_first_char) begin
        p.has = 1'b1;
        p.res = done_res_f(ST_LATE_QUOTE, 8'd0, s.byte_count);
        p.st  = '0;
      end else begin
        p.st.inside_quotes   = 1'b1;
        p.st.past_first_char = 1'b1;
      end
    end else if (qr && !s.inside_quotes) begin
      p.has = 1'b1;
      p.res = done_res_f(ST_MISSING_QUOTE, c, s.byte_count);
      p.st  = '0;
    end else begin
      p.st.past_first_char = 1'b1;
      if (c == CH_BSLASH) begin
        p.st.in_escape   = 1'b1;
        p.st.digit_count = 2'd0;
        p.st.digit_value = 8'd0;
      end else begin
        p.has             = 1'b1;
        p.st.byte_count   = sat_inc(s.byte_count);
        p.res             = byte_res(c, p.st.byte_count);
      end
    end
    plain_char = p;
  endfunction

  logic        is_digit;
  logic [7:0]  dv_new;
  logic [7:0]  named_byte;
  logic        named_ok;
  logic [15:0] len_inc;
  state_t      st_esc_end;
  plain_out_t  plain_a;
  plain_out_t  plain_b;

  assign is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
  assign dv_new   = {st.digit_value[4:0], 3'b000} + (char_in - CH_ZERO);
  assign len_inc  = sat_inc(st.byte_count);

  always_comb begin
    named_ok   = 1'b1;
    named_byte = 8'd0;
    unique case (char_in)
      CH_A:      named_byte = BY_BEL;
      CH_B:      named_byte = BY_BS;
      CH_F:      named_byte = BY_FF;
      CH_N:      named_byte = BY_LF;
      CH_R:      named_byte = BY_CR;
      CH_T:      named_byte = BY_HT;
      CH_V:      named_byte = BY_VT;
      CH_BSLASH: named_byte = CH_BSLASH;
      CH_QUOTE:  named_byte = CH_QUOTE;
      default:   named_ok   = 1'b0;
    endcase
  end

  always_comb begin
    st_esc_end             = st;
    st_esc_end.in_escape   = 1'b0;
    st_esc_end.digit_count = 2'd0;
    st_esc_end.digit_value = 8'd0;
    st_esc_end.byte_count  = len_inc;
  end

  assign plain_a = plain_char(st, quote_required, char_in);
  assign plain_b = plain_char(st_esc_end, quote_required, char_in);

  always_comb begin
    st_next   = st;
    res0      = '0;
    res1      = '0;
    res_count = 2'd0;
    if (end_of_text) begin
      st_next   = '0;
      res_count = 2'd1;
      if (st.inside_quotes) begin
        res0 = done_res_f(ST_UNTERMINATED, 8'd0, st.byte_count);
      end else if (quote_required) begin
        res0 = done_res_f(ST_MISSING_QUOTE, 8'd0, st.byte_count);
      end else if (st.in_escape && st.digit_count == 2'd0) begin
        res0 = done_res_f(ST_BAD_ESCAPE, 8'd0, st.byte_count);
      end else if (st.in_escape) begin
        res0      = byte_res(st.digit_value, len_inc);
        res1      = done_res_f(ST_OK, 8'd0, len_inc);
        res_count = 2'd2;
      end else begin
        res0 = done_res_f(ST_OK, 8'd0, st.byte_count);
      end
    end else if (st.in_escape) begin
      if (is_digit) begin
        if (st.digit_count == 2'd2) begin
          st_next   = st_esc_end;
          res0      = byte_res(dv_new, len_inc);
          res_count = 2'd1;
        end else begin
          st_next.digit_value = dv_new;
          st_next.digit_count = st.digit_count + 2'd1;
        end
      end else if (st.digit_count != 2'd0) begin
        res0      = byte_res(st.digit_value, len_inc);
        st_next   = plain_b.st;
        res1      = plain_b.res;
        res_count = plain_b.has ? 2'd2 : 2'd1;
      end else if (named_ok) begin
        st_next   = st_esc_end;
        res0      = byte_res(named_byte, len_inc);
        res_count = 2'd1;
      end else begin
        st_next   = '0;
        res0      = done_res_f(ST_BAD_ESCAPE, char_in, st.byte_count);
        res_count = 2'd1;
      end
    end else begin
      st_next   = plain_a.st;
      res0      = plain_a.res;
      res_count = plain_a.has ? 2'd1 : 2'd0;
    end
    res0.last = (res_count == 2'd1);
    res1.last = 1'b1;
  end

endmodule

`default_nettype wire

// ===== rtl/csed_outq.sv =====
`default_nettype none

module csed_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  csed_pkg::result_t push0,
  input  csed_pkg::result_t push1,
  output logic              room,
  output logic              pop_valid,
  input  logic              pop_ready,
  output csed_pkg::result_t head
);
  import csed_pkg::*;

  result_t         mem [OqDepth];
  logic [OqAw-1:0] wr_ptr;
  logic [OqAw-1:0] rd_ptr;
  logic [OqCw-1:0] count;
  logic            pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (count != '0);
  assign room      = (count <= OqCw'(OqDepth - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OqAw'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + OqAw'(1);
      end
      count <= count + OqCw'(push_count) - OqCw'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr + OqAw'(1)] <= push1;
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import csed_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int MaxReports = 100;
  localparam int RandomItemsPerPhase = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic cfg_write_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] char_in = 8'h00;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] data_byte;
  logic byte_valid;
  logic done_res;
  logic [2:0] status;
  logic [7:0] bad_char;
  logic [15:0] decoded_length;
  logic last;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  logic quote_req_shadow = 1'b0;
  logic esc_pending = 1'b0;
  logic [1:0] oct_digits = 2'd0;
  logic [7:0] oct_value = 8'h00;
  logic in_quotes = 1'b0;
  logic seen_first = 1'b0;
  logic [15:0] byte_total = 16'd0;
  result_t due_results[$];

  c_string_escape_decoder dut (
    .clk(clk),
    .rst(rst),
    .cfg_write_en(cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_in(char_in),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data_byte(data_byte),
    .byte_valid(byte_valid),
    .done_res(done_res),
    .status(status),
    .bad_char(bad_char),
    .decoded_length(decoded_length),
    .last(last)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void push_result(logic [7:0] b, logic is_byte, logic is_done,
                                      status_t st, logic [7:0] bad);
    result_t r;
    r.data_byte = b;
    r.byte_valid = is_byte;
    r.done_res = is_done;
    r.status = st;
    r.bad_char = bad;
    r.decoded_length = byte_total;
    r.last = 1'b0;
    due_results.push_back(r);
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (byte_total != LEN_MAX) byte_total++;
    push_result(b, 1'b1, 1'b0, ST_OK, 8'h00);
  endfunction

  function automatic void end_literal(status_t st, logic [7:0] bad);
    push_result(8'h00, 1'b0, 1'b1, st, bad);
    esc_pending = 1'b0;
    oct_digits = 2'd0;
    oct_value = 8'h00;
    in_quotes = 1'b0;
    seen_first = 1'b0;
    byte_total = 16'd0;
  endfunction

  function automatic void leave_escape();
    esc_pending = 1'b0;
    oct_digits = 2'd0;
    oct_value = 8'h00;
  endfunction

  function automatic void take_plain(logic [7:0] c);
    if (c == CH_QUOTE) begin
      if (in_quotes) end_literal(ST_OK, 8'h00);
      else if (seen_first) end_literal(ST_LATE_QUOTE, 8'h00);
      else begin
        in_quotes = 1'b1;
        seen_first = 1'b1;
      end
    end else if (quote_req_shadow && !in_quotes) begin
      end_literal(ST_MISSING_QUOTE, c);
    end else begin
      seen_first = 1'b1;
      if (c == CH_BSLASH) begin
        leave_escape();
        esc_pending = 1'b1;
      end else begin
        put_byte(c);
      end
    end
  endfunction

  function automatic void decode_char(logic [7:0] c, logic eot);
    int n_before;
    logic [7:0] v;
    logic named_ok;
    result_t r;
    n_before = due_results.size();
    if (eot) begin
      if (in_quotes) end_literal(ST_UNTERMINATED, 8'h00);
      else if (quote_req_shadow) end_literal(ST_MISSING_QUOTE, 8'h00);
      else if (esc_pending && oct_digits == 2'd0) end_literal(ST_BAD_ESCAPE, 8'h00);
      else begin
        if (esc_pending) put_byte(oct_value);
        end_literal(ST_OK, 8'h00);
      end
    end else if (esc_pending) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        oct_value = (oct_value << 3) + (c - CH_ZERO);
        oct_digits++;
        if (oct_digits == 2'd3) begin
          v = oct_value;
          leave_escape();
          put_byte(v);
        end
      end else if (oct_digits != 2'd0) begin
        v = oct_value;
        leave_escape();
        put_byte(v);
        take_plain(c);
      end else begin
        named_ok = 1'b1;
        v = 8'h00;
        case (c)
          CH_A: v = BY_BEL;
          CH_B: v = BY_BS;
          CH_F: v = BY_FF;
          CH_N: v = BY_LF;
          CH_R: v = BY_CR;
          CH_T: v = BY_HT;
          CH_V: v = BY_VT;
          CH_BSLASH: v = CH_BSLASH;
          CH_QUOTE: v = CH_QUOTE;
          default: named_ok = 1'b0;
        endcase
        if (named_ok) begin
          leave_escape();
          put_byte(v);
        end else begin
          end_literal(ST_BAD_ESCAPE, c);
        end
      end
    end else begin
      take_plain(c);
    end
    if (due_results.size() > n_before) begin
      r = due_results.pop_back();
      r.last = 1'b1;
      due_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MaxReports)
        $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports)
          $display("%0t ns: result expected none, got data_byte %0h done_res %0b status %0d",
                   $time, data_byte, done_res, status);
      end else begin
        want = due_results.pop_front();
        check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
        check_field("byte_valid", 32'(want.byte_valid), 32'(byte_valid));
        check_field("done_res", 32'(want.done_res), 32'(done_res));
        check_field("status", 32'(want.status), 32'(status));
        check_field("bad_char", 32'(want.bad_char), 32'(bad_char));
        check_field("decoded_length", 32'(want.decoded_length), 32'(decoded_length));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_char(logic [7:0] c, logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    end_of_text <= eot;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    decode_char(c, eot);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_quote_required(logic v);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    quote_req_shadow = v;
  endtask

  function automatic logic [7:0] random_plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic test_named_escapes();
    set_quote_required(1'b0);
    send_char(8'h00, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("\\a\\b\\f\\n\\r\\t\\v\\\\\\\"");
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_octal_escapes();
    send_text("\\777\\9\"");
    send_text("\\q");
    send_text("\\");
    send_char(8'h00, 1'b1);
    send_text("\\12");
    send_char(8'h00, 1'b1);
  endtask

  task automatic test_quote_rules();
    set_quote_required(1'b1);
    send_text("x");
    send_char(8'h00, 1'b1);
    send_text("\"A");
    send_char(8'h00, 1'b1);
    send_text("\"B\"");
    set_quote_required(1'b0);
  endtask

  task automatic send_random_literal();
    int nparts;
    int p;
    int e;
    logic quoted_lit;
    logic [7:0] c;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
      return;
    end
    quoted_lit = quote_req_shadow ? ($urandom_range(9) != 0) : ($urandom_range(1) == 1);
    if (quoted_lit) send_char(CH_QUOTE, 1'b0);
    nparts = $urandom_range(0, 8);
    for (int i = 0; i < nparts; i++) begin
      p = $urandom_range(99);
      if (p < 50) begin
        send_char(random_plain_byte(), 1'b0);
      end else if (p < 70) begin
        case ($urandom_range(8))
          0: c = CH_A;
          1: c = CH_B;
          2: c = CH_F;
          3: c = CH_N;
          4: c = CH_R;
          5: c = CH_T;
          6: c = CH_V;
          7: c = CH_BSLASH;
          default: c = CH_QUOTE;
        endcase
        send_char(CH_BSLASH, 1'b0);
        send_char(c, 1'b0);
      end else if (p < 88) begin
        send_char(CH_BSLASH, 1'b0);
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
      end else if (p < 94) begin
        send_char(CH_BSLASH, 1'b0);
        send_char(8'($urandom_range(255)), 1'b0);
      end else begin
        send_char(CH_QUOTE, 1'b0);
      end
    end
    e = $urandom_range(9);
    if (quoted_lit && e < 8) send_char(CH_QUOTE, 1'b0);
    if (!quoted_lit || e >= 6) send_char(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_random_traffic(int idle, int stall, logic qr);
    int target;
    set_quote_required(qr);
    send_idle_pct = idle;
    stall_pct = stall;
    target = items_sent + RandomItemsPerPhase;
    while (items_sent < target) send_random_literal();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_named_escapes();
    test_octal_escapes();
    test_quote_rules();
    test_random_traffic(0, 0, 1'b0);
    test_random_traffic(82, 0, 1'b1);
    test_random_traffic(0, 82, 1'b0);
    test_random_traffic(38, 38, 1'b1);
    wait_drained();
    repeat (6) @(negedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
